[rtl/bdc_pkg.sv]
// Shared constants and types of the de Casteljau Bezier evaluator.
`default_nettype none
package bdc_pkg;

	localparam int NUM_POINTS_DEF = 4;

	localparam logic [16:0] T_ONE        = 17'h10000;
	localparam logic [4:0]  POINTS_RESET = 5'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Per-cycle control from the sequencer to the datapath
	typedef struct packed {
		logic step;     // one blend step this cycle
		logic last;     // final step of the current level
		logic done_go;  // move the surviving point to the output register
	} seq_ctl_t;

endpackage
`default_nettype wire

[rtl/bdc_blend.sv]
// Rounded linear interpolation unit: a + round(t * (b - a) / 2^16).
`default_nettype none
module bdc_blend import bdc_pkg::*; (
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	input  logic        [16:0] t,
	output logic signed [15:0] y
);

	logic signed [16:0] diff;
	logic signed [34:0] prod;
	logic signed [34:0] rnd;
	logic signed [18:0] q;
	logic signed [18:0] sum;

	// (1-t)*a + t*b == a + t*(b-a); floor of the biased shift rounds ties upward
	always_comb begin
		diff = $signed({b[15], b}) - $signed({a[15], a});
		prod = $signed({1'b0, t}) * diff;
		rnd  = prod + 35'sd32768;
		q    = rnd[34:16];
		sum  = q + $signed({{3{a[15]}}, a});
		y    = sum[15:0];
	end

endmodule
`default_nettype wire

[rtl/bdc_seq.sv]
// Sequencer: walks the de Casteljau levels one blend step per cycle.
`default_nettype none
module bdc_seq import bdc_pkg::*; #(
	parameter  int NUM_POINTS = NUM_POINTS_DEF,
	localparam int IW = $clog2(NUM_POINTS),
	localparam int LW = $clog2(NUM_POINTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          eval_go,
	input  logic [4:0]    pts,
	input  logic [16:0]   t_in,
	input  logic          out_free,
	output logic          idle,
	output logic [16:0]   t_q,
	output logic [IW-1:0] wr_idx,
	output seq_ctl_t      ctl
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t        state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] n_eff;
	logic [LW-1:0] len_m1;
	logic [LW-1:0] len_m2;
	logic          last;

	// degree clamp: above the store acts as full, 0 or 1 acts as a single point
	always_comb begin
		if (int'(pts) > NUM_POINTS)
			n_eff = LW'(NUM_POINTS);
		else if (pts == 5'd0)
			n_eff = LW'(1);
		else
			n_eff = LW'(pts);
	end

	assign len_m1 = len_q - LW'(1);
	assign len_m2 = len_q - LW'(2);
	assign last   = (cnt_q == len_m2);
	assign wr_idx = last ? len_m2[IW-1:0] : len_m1[IW-1:0];

	assign idle        = (state_q == S_IDLE);
	assign ctl.step    = (state_q == S_RUN);
	assign ctl.last    = (state_q == S_RUN) && last;
	assign ctl.done_go = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk) begin
		if (idle && eval_go)
			t_q <= (t_in > T_ONE) ? T_ONE : t_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (eval_go) begin
						len_q   <= n_eff;
						cnt_q   <= '0;
						state_q <= (n_eff == LW'(1)) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					if (last) begin
						len_q <= len_m1;
						cnt_q <= '0;
						if (len_q == LW'(2))
							state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + LW'(1);
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/bezier_de_casteljau_eval_core.sv]
// Top level of the de Casteljau Bezier curve evaluator.
//
// Channels: an input request (opcode, point_index, point_x, point_y, t_param)
// on in_valid/in_ready, a result request (curve_x, curve_y) on
// out_valid/out_ready, and a config write (cfg_data = points_in_use) on
// cfg_valid/cfg_ready, which is always ready.
// A load request writes one control point in the accept cycle, gives no
// result, and the block is ready again at once. A load to an index at or
// beyond NUM_POINTS is dropped.
// An evaluate request copies the control points into a work line, then one
// shared x/y blend pair does one lerp per cycle, n*(n-1)/2 lerps for n
// points (6 for a cubic), and a final step moves the point to the output
// register. in_ready stays low from acceptance until that move, so no new
// request is taken while an evaluate is still running.
// The work line always reads its first two entries and shifts, so the
// blend pair is the one arithmetic unit and sets the rate.
// When the receiver stalls, the result sits in the output register and the
// next evaluate holds in its final state until the register frees up.
// Reset (arst_n, async): idle, no pending result, control points zero,
// points_in_use = 4. No clearing pass is needed.
`default_nettype none
module bezier_de_casteljau_eval_core import bdc_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [3:0]         point_index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [16:0]        t_param,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] curve_x,
	output logic signed [15:0] curve_y
);

	localparam int IW = $clog2(NUM_POINTS);

	logic [4:0]         pts_q;
	logic signed [15:0] ctl_x_q [NUM_POINTS];
	logic signed [15:0] ctl_y_q [NUM_POINTS];
	logic signed [15:0] wk_x_q  [NUM_POINTS];
	logic signed [15:0] wk_y_q  [NUM_POINTS];
	logic signed [15:0] bl_x;
	logic signed [15:0] bl_y;
	logic signed [15:0] curve_x_q;
	logic signed [15:0] curve_y_q;
	logic               out_valid_q;
	logic               in_fire;
	logic               eval_go;
	logic               load_go;
	logic               out_free;
	logic               idle;
	logic [16:0]        t_q;
	logic [IW-1:0]      wr_idx;
	seq_ctl_t           ctl;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign in_fire   = in_valid && in_ready;
	assign eval_go   = in_fire && (opcode == OP_EVAL);
	assign load_go   = in_fire && (opcode == OP_LOAD) && (int'(point_index) < NUM_POINTS);
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign curve_x   = curve_x_q;
	assign curve_y   = curve_y_q;

	bdc_seq #(.NUM_POINTS(NUM_POINTS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.eval_go  (eval_go),
		.pts      (pts_q),
		.t_in     (t_param),
		.out_free (out_free),
		.idle     (idle),
		.t_q      (t_q),
		.wr_idx   (wr_idx),
		.ctl      (ctl)
	);

	// shared blend pair, always fed from the head of the work line
	bdc_blend u_blend_x (.a(wk_x_q[0]), .b(wk_x_q[1]), .t(t_q), .y(bl_x));
	bdc_blend u_blend_y (.a(wk_y_q[0]), .b(wk_y_q[1]), .t(t_q), .y(bl_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pts_q <= POINTS_RESET;
		else if (cfg_valid && cfg_ready)
			pts_q <= cfg_data;
	end

	// control point store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_POINTS; k++) begin
				ctl_x_q[k] <= '0;
				ctl_y_q[k] <= '0;
			end
		end else if (load_go) begin
			ctl_x_q[point_index[IW-1:0]] <= point_x;
			ctl_y_q[point_index[IW-1:0]] <= point_y;
		end
	end

	// Work line: a mid-level step shifts by one and appends the blend at the
	// level's tail; the level's last step shifts by two, dropping the spent
	// head point, and the blend lands one slot earlier.
	always_ff @(posedge clk) begin
		if (eval_go) begin
			for (int k = 0; k < NUM_POINTS; k++) begin
				wk_x_q[k] <= ctl_x_q[k];
				wk_y_q[k] <= ctl_y_q[k];
			end
		end else if (ctl.step) begin
			for (int k = 0; k < NUM_POINTS; k++) begin
				if (IW'(k) == wr_idx) begin
					wk_x_q[k] <= bl_x;
					wk_y_q[k] <= bl_y;
				end else if (ctl.last) begin
					wk_x_q[k] <= wk_x_q[(k + 2 < NUM_POINTS) ? k + 2 : NUM_POINTS - 1];
					wk_y_q[k] <= wk_y_q[(k + 2 < NUM_POINTS) ? k + 2 : NUM_POINTS - 1];
				end else begin
					wk_x_q[k] <= wk_x_q[(k + 1 < NUM_POINTS) ? k + 1 : NUM_POINTS - 1];
					wk_y_q[k] <= wk_y_q[(k + 1 < NUM_POINTS) ? k + 1 : NUM_POINTS - 1];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.done_go) begin
			curve_x_q <= wk_x_q[0];
			curve_y_q <= wk_y_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.done_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// an evaluate always takes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_go |=> !in_ready)
		else $error("block ready right after an evaluate request");

	// a load never takes the block busy
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (opcode == OP_LOAD)) |=> in_ready)
		else $error("block busy after a load request");

	// a new result only comes from the sequencer's final move
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.done_go))
		else $error("result raised without a finished evaluation");

	// the blend pair only runs while the input side is closed
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step || ctl.done_go) |-> !in_ready)
		else $error("evaluation running while input is open");

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for bezier_de_casteljau_eval_core: random and directed requests vs. a predictor.
`timescale 1ns / 100ps
module testbench;
	import bdc_pkg::*;

	// Point store depth; the core runs with its default
	localparam int NPTS = NUM_POINTS_DEF;
	// Generous bound: ~1400 requests plus the long hold
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 20;
	localparam int N_PHASES = 9;
	localparam int PER_PHASE = 155;

	typedef struct {
		logic               op;
		logic [3:0]         idx;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [16:0]        t;
	} req_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} pt_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [4:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               opcode = OP_LOAD;
	logic [3:0]         point_index = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic [16:0]        t_param = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] curve_x;
	logic signed [15:0] curve_y;

	bezier_de_casteljau_eval_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.t_param     (t_param),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.curve_x     (curve_x),
		.curve_y     (curve_y)
	);

	// Requests waiting for the driver, curve points waiting for the core
	req_t pending_reqs[$];
	pt_t  curve_expect[$];

	// Shadow of the core's state: control points and points_in_use
	logic signed [15:0] ctl_x[NPTS];
	logic signed [15:0] ctl_y[NPTS];
	logic [4:0]         pts_cfg = POINTS_RESET;

	int mismatch_count = 0;
	int cycle_count = 0;

	// Sender burst shaping
	int burst_left = 1;
	int gap_left = 0;

	// Receiver stall pattern and the one long hold-off
	logic       hold_arm = 1'b0;
	logic       hold_done = 1'b0;
	int         hold_left = 0;
	logic [1:0] rx_mode = '0;
	logic [7:0] rx_tick = '0;
	logic [15:0] rx_bits = '0;

	initial begin
		for (int i = 0; i < NPTS; i++) begin
			ctl_x[i] = '0;
			ctl_y[i] = '0;
		end
	end

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		// keep the log short when something is badly broken
		if (mismatch_count <= 20)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// One rounded lerp step: floor(((1-t)*a + t*b + half) / one), ties toward +inf
	function automatic logic signed [15:0] lerp_round(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic [16:0] t);
		longint s;
		s = longint'(T_ONE - t) * longint'(a) + longint'(t) * longint'(b);
		s = (s + 32768) >>> 16;
		return s[15:0];
	endfunction

	// Apply one accepted request to the shadow state; evaluates queue a curve point
	task automatic apply_request(input req_t r);
		logic signed [15:0] wx[NPTS];
		logic signed [15:0] wy[NPTS];
		logic [16:0] tc;
		int n;
		pt_t p;
		if (r.op == OP_LOAD) begin
			// loads beyond the store are dropped
			if (r.idx < NPTS) begin
				ctl_x[r.idx] = r.px;
				ctl_y[r.idx] = r.py;
			end
		end else begin
			// parameter above one saturates to one
			tc = (r.t > T_ONE) ? T_ONE : r.t;
			// degree clamps: too many acts as the store size, fewer than two gives point 0
			n = int'(pts_cfg);
			if (n > NPTS)
				n = NPTS;
			if (n < 1)
				n = 1;
			for (int i = 0; i < n; i++) begin
				wx[i] = ctl_x[i];
				wy[i] = ctl_y[i];
			end
			for (int len = n; len > 1; len--) begin
				for (int i = 0; i + 1 < len; i++) begin
					wx[i] = lerp_round(wx[i], wx[i + 1], tc);
					wy[i] = lerp_round(wy[i], wy[i + 1], tc);
				end
			end
			p.x = wx[0];
			p.y = wy[0];
			curve_expect.insert(curve_expect.size(), p);
		end
	endtask

	// Driver: pops pending requests in bursts with random gaps; valid holds until taken
	always @(posedge clk) begin : req_driver
		req_t seen;
		req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				seen = '{opcode, point_index, point_x, point_y, t_param};
				apply_request(seen);
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.op;
					point_index <= nxt.idx;
					point_x <= nxt.px;
					point_y <= nxt.py;
					t_param <= nxt.t;
					if (burst_left <= 1) begin
						burst_left <= int'($urandom_range(1, 40));
						// a quarter of the bursts run back to back
						gap_left <= int'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the result side, armed once by the stimulus
	always @(posedge clk) begin : long_hold
		if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: picks a new stall mode each time the 8-bit rx_tick wraps
	always @(posedge clk) begin : result_sink
		logic go;
		if (rx_tick == 0) begin
			rx_mode <= 2'($urandom_range(0, 3));
			rx_bits <= 16'($urandom);
		end
		rx_tick <= rx_tick + 8'd1;
		case (rx_mode)
			2'd0: go = 1'b1;
			2'd1: go = 1'($urandom_range(0, 1));
			2'd2: go = ($urandom_range(0, 3) == 0);
			default: go = rx_bits[rx_tick[3:0]];
		endcase
		out_ready <= (hold_left == 0) && go;
	end

	// Monitor: each taken curve point against the oldest expectation
	always @(posedge clk) begin : result_check
		pt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (curve_expect.size() == 0) begin
				flag_mismatch($sformatf("unexpected curve point x=%0d y=%0d", curve_x, curve_y));
			end else begin
				want = curve_expect.pop_front();
				if (curve_x !== want.x)
					flag_mismatch($sformatf("curve_x %0d, want %0d", curve_x, want.x));
				if (curve_y !== want.y)
					flag_mismatch($sformatf("curve_y %0d, want %0d", curve_y, want.y));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_req(input req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic push_load(input int idx, input logic signed [15:0] x,
		input logic signed [15:0] y);
		queue_req('{OP_LOAD, 4'(idx), x, y, 17'd0});
	endtask

	task automatic push_eval(input logic [16:0] t);
		queue_req('{OP_EVAL, 4'd0, 16'sd0, 16'sd0, t});
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly interior t, with the ends and the saturating range mixed in
	function automatic logic [16:0] rand_t();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return T_ONE;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// Mostly load-then-evaluate sequences, some raw noise (any opcode, any index)
	task automatic fill_random(input int count);
		int made;
		int nl;
		int ne;
		req_t r;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) < 7) begin
				nl = int'($urandom_range(0, NPTS));
				for (int i = 0; i < nl; i++) begin
					push_load(int'($urandom_range(0, NPTS - 1)), rand_coord(), rand_coord());
					made++;
				end
				ne = int'($urandom_range(1, 4));
				for (int i = 0; i < ne; i++) begin
					push_eval(rand_t());
					made++;
				end
			end else begin
				r.op = 1'($urandom_range(0, 1));
				r.idx = 4'($urandom_range(0, 15));
				r.px = 16'($urandom);
				r.py = 16'($urandom);
				r.t = 17'($urandom_range(0, 131071));
				queue_req(r);
				// dropped loads do not count
				if (!(r.op == OP_LOAD && r.idx >= NPTS))
					made++;
			end
		end
	endtask

	// Idle: nothing queued, nothing offered, nothing owed; then let the core settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || curve_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_points_in_use(input logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pts_cfg = v;
	endtask

	// Stimulus: one phase per points_in_use setting, directed requests first
	initial begin : stimulus
		logic [4:0] cfg_plan[N_PHASES];
		cfg_plan = '{5'd4, 5'd2, 5'd3, 5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd4};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			write_points_in_use(cfg_plan[ph]);
			@(negedge clk);
			if (ph == 0) begin
				// coordinate extremes in every slot
				push_load(0, 16'sh8000, 16'sh7fff);
				push_load(1, 16'sh7fff, 16'sh8000);
				push_load(2, 16'sh8000, 16'sh8000);
				push_load(3, 16'sh7fff, 16'sh7fff);
				// t at both ends, the middle, next to the ends, above one
				push_eval(17'd0);
				push_eval(T_ONE);
				push_eval(17'd32768);
				push_eval(17'd1);
				push_eval(17'd65535);
				push_eval(17'd65537);
				push_eval(17'h1ffff);
				// loads past the store must not disturb it
				push_load(4, 16'sh1234, -16'sh0567);
				push_load(15, 16'sh0000, 16'sh0000);
				push_eval(17'd32768);
				push_load(3, 16'sh0000, 16'sh0000);
				push_eval(17'd49152);
			end
			fill_random(PER_PHASE);
			// back up the core while the sender keeps offering
			if (ph == 0)
				hold_arm = 1'b1;
		end

		wait_idle();
		if (curve_expect.size() != 0)
			flag_mismatch($sformatf("%0d curve points never came", curve_expect.size()));
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
